@@ src/ims_pkg.sv @@
// Shared types, constants and helpers for the Ising spin sampler.
`timescale 1ns / 1ps
package ims_pkg;

    // Sizing of the spin system and the coupling storage.
    localparam int NUM_SPINS     = 4;
    localparam int COUPLING_BITS = 16;
    localparam int NUM_PAIRS     = (NUM_SPINS * (NUM_SPINS - 1)) / 2;
    localparam int IDX_W         = $clog2(NUM_SPINS);
    localparam int PAIR_W        = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
    localparam int ACC_W         = COUPLING_BITS + $clog2(NUM_SPINS);
    localparam int DE_W          = ACC_W + 1;
    localparam int BUDGET_W      = 18;
    localparam int CMP_W         = (DE_W > BUDGET_W + 1) ? DE_W : BUDGET_W + 1;
    localparam int STEPS_W       = 10;
    localparam int OUT_SPINS_W   = 4;
    localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(100);

    // Request command codes as they arrive on the input channel.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TRY   = 2'd2;

    // Operation codes carried through the queue.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TRY   = 2'd2;

    typedef struct packed {
        logic [1:0]                       kind;
        logic [NUM_SPINS-1:0]             pattern;
        logic [PAIR_W-1:0]                slot;
        logic signed [COUPLING_BITS-1:0]  value;
        logic                             no_flip;
        logic [IDX_W-1:0]                 idx;
        logic [BUDGET_W-1:0]              budget;
    } t_op;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_head;

    // Row-by-row slot of pair (a,b), a != b.
    function automatic logic [PAIR_W-1:0] pair_slot(input logic [IDX_W-1:0] a,
                                                    input logic [IDX_W-1:0] b);
        int lo;
        int hi;
        int s;
        begin
            lo = (a < b) ? int'(a) : int'(b);
            hi = (a < b) ? int'(b) : int'(a);
            s  = lo * NUM_SPINS - (lo * (lo + 1)) / 2 + (hi - lo - 1);
            return PAIR_W'(s);
        end
    endfunction

endpackage

@@ src/ims_front.sv @@
// Front end: accepts requests, classifies them and queues the useful ones.
`timescale 1ns / 1ps
module ims_front
    import ims_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_cmd,
    input  logic [3:0]          i_spin_pattern,
    input  logic [2:0]          i_pair_index,
    input  logic signed [15:0]  i_coupling_value,
    input  logic                i_skip,
    input  logic [1:0]          i_spin_index,
    input  logic [17:0]         i_uphill_budget,
    output t_head               o_head,
    input  logic                i_pop
);

    t_op         r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        n_wr_ptr;
    logic        n_rd_ptr;
    logic [1:0]  n_count;

    logic        accept;
    logic        keep;
    logic        push;
    logic        pop;
    t_op         op;

    assign o_in_stall = (r_count == 2'd2);
    assign accept     = i_in_valid && !o_in_stall;

    // Decode; unused commands and out-of-range pairs are dropped here.
    always_comb begin
        op         = '0;
        op.pattern = NUM_SPINS'(i_spin_pattern);
        op.slot    = PAIR_W'(i_pair_index);
        op.value   = COUPLING_BITS'(i_coupling_value);
        op.idx     = IDX_W'(i_spin_index);
        op.budget  = i_uphill_budget;
        op.no_flip = i_skip || (32'(i_spin_index) >= NUM_SPINS);
        keep       = 1'b0;
        unique case (i_cmd)
            CMD_LOAD: begin
                op.kind = OP_LOAD;
                keep    = 1'b1;
            end
            CMD_WRITE: begin
                op.kind = OP_WRITE;
                keep    = (32'(i_pair_index) < NUM_PAIRS);
            end
            CMD_TRY: begin
                op.kind = OP_TRY;
                keep    = 1'b1;
            end
            default: begin
                op.kind = OP_LOAD;
                keep    = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;
    assign pop  = i_pop && (r_count != 2'd0);

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.op    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= op;
        end
    end

endmodule

@@ src/ims_back.sv @@
// Back end: spin and coupling state, energy sum, accept test and sample output.
`timescale 1ns / 1ps
module ims_back
    import ims_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [STEPS_W-1:0]      i_cfg_wdata,
    input  t_head                   i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [OUT_SPINS_W-1:0]  o_spins
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SUM    = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    logic [NUM_SPINS-1:0]             r_spins;
    logic [NUM_SPINS-1:0]             n_spins;
    logic signed [COUPLING_BITS-1:0]  r_table [NUM_PAIRS];
    logic [STEPS_W-1:0]               r_steps;
    logic [STEPS_W-1:0]               r_cnt;
    logic [STEPS_W-1:0]               n_cnt;
    logic signed [ACC_W-1:0]          r_acc;
    logic signed [ACC_W-1:0]          n_acc;
    logic [IDX_W-1:0]                 r_j;
    logic [IDX_W-1:0]                 n_j;
    logic [IDX_W-1:0]                 r_idx;
    logic                             r_no_flip;
    logic [BUDGET_W-1:0]              r_budget;
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [OUT_SPINS_W-1:0]           r_out_spins;
    logic [OUT_SPINS_W-1:0]           n_out_spins;

    logic                             take;
    logic                             out_free;
    logic signed [ACC_W-1:0]          term;
    logic signed [DE_W-1:0]           de_pos;
    logic signed [DE_W-1:0]           de;
    logic signed [CMP_W-1:0]          de_ext;
    logic signed [CMP_W-1:0]          budget_ext;
    logic                             flip;
    logic [STEPS_W-1:0]               cnt_inc;
    logic                             emit;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign take        = (r_state == S_IDLE) && i_head.valid;
    assign o_pop       = take;
    assign o_out_valid = r_out_valid;
    assign o_spins     = r_out_spins;

    // One coupling term per cycle; the j == i step adds nothing.
    assign term = ACC_W'(r_table[pair_slot(r_idx, r_j)]);

    assign de_pos     = DE_W'(r_acc) <<< 1;
    assign de         = r_spins[r_idx] ? de_pos : -de_pos;
    assign de_ext     = CMP_W'(de);
    assign budget_ext = $signed(CMP_W'(r_budget));
    assign flip       = !r_no_flip && (de_ext <= budget_ext);
    assign cnt_inc    = r_cnt + STEPS_W'(1);
    assign emit       = (cnt_inc >= r_steps);

    always_comb begin
        n_state     = r_state;
        n_spins     = r_spins;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_j         = r_j;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_spins = r_out_spins;
        unique case (r_state)
            S_IDLE: begin
                n_acc = '0;
                n_j   = '0;
                if (take) begin
                    if (i_head.op.kind == OP_LOAD) begin
                        n_spins = i_head.op.pattern;
                    end else if (i_head.op.kind == OP_TRY) begin
                        n_state = i_head.op.no_flip ? S_DECIDE : S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (r_j != r_idx) begin
                    n_acc = r_spins[r_j] ? r_acc + term : r_acc - term;
                end
                n_j = r_j + IDX_W'(1);
                if (r_j == IDX_W'(NUM_SPINS - 1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    if (flip) begin
                        n_spins = r_spins ^ (NUM_SPINS'(1) << r_idx);
                    end
                    if (emit) begin
                        n_cnt       = '0;
                        n_out_valid = 1'b1;
                        n_out_spins = OUT_SPINS_W'(n_spins);
                    end else begin
                        n_cnt = cnt_inc;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spins     <= '0;
            r_cnt       <= '0;
            r_steps     <= STEPS_RESET;
            r_out_valid <= 1'b0;
            for (int p = 0; p < NUM_PAIRS; p++) begin
                r_table[p] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_spins     <= n_spins;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_steps <= i_cfg_wdata;
            end
            if (take && (i_head.op.kind == OP_WRITE)) begin
                r_table[i_head.op.slot] <= i_head.op.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_j         <= n_j;
        r_out_spins <= n_out_spins;
        if (take) begin
            r_idx     <= i_head.op.idx;
            r_no_flip <= i_head.op.no_flip;
            r_budget  <= i_head.op.budget;
        end
    end

endmodule

@@ src/ising_metropolis_spin_sampler_top.sv @@
// Top level of the Metropolis Ising spin sampler: front end, queue and back end.
//
//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  ---------------------------------
//  in        in         i_in_valid / o_in_stall     i_cmd, i_spin_pattern, i_pair_index,
//                                                   i_coupling_value, i_skip,
//                                                   i_spin_index, i_uphill_budget
//  out       out        o_out_valid / i_out_stall   o_spins
//  cfg       in         i_cfg_we                    i_cfg_wdata (steps_per_sample)
//
//  Spin load and coupling write finish in the back end's idle state; a skipped attempt
//  goes on to the decide state; a full attempt first passes through the sum state,
//  which adds one coupling term per cycle. Unused commands never reach the back end.
//  A two-entry request queue keeps the input side open while the back end works
//  or waits on a stalled output register.
//  Synchronous active-low reset: all spins -1, couplings zero, count zero,
//  period 100.
`timescale 1ns / 1ps
module ising_metropolis_spin_sampler_top
    import ims_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [9:0]          i_cfg_wdata,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_cmd,
    input  logic [3:0]          i_spin_pattern,
    input  logic [2:0]          i_pair_index,
    input  logic signed [15:0]  i_coupling_value,
    input  logic                i_skip,
    input  logic [1:0]          i_spin_index,
    input  logic [17:0]         i_uphill_budget,
    // sample channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [3:0]          o_spins
);

    t_head  head;   // queue head offered to the back end
    logic   pop;    // back end takes the head

    ims_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_spin_pattern   (i_spin_pattern),
        .i_pair_index     (i_pair_index),
        .i_coupling_value (i_coupling_value),
        .i_skip           (i_skip),
        .i_spin_index     (i_spin_index),
        .i_uphill_budget  (i_uphill_budget),
        .o_head           (head),
        .i_pop            (pop)
    );

    // Back end holds all architectural state and the sample output register.
    ims_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_spins      (o_spins)
    );

endmodule
